FILE: hdl/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared types and codes of the sorted list engine
// Operation and status codes, the per-cell command and the control bundle
// that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_POP    = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd2;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_SHIFT,
        CMD_COMPACT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic signed [VALUE_W-1:0] operand;
    } cell_ctrl_t;

endpackage

FILE: hdl/sle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted chain
// Holds one value, compares it against the broadcast operand and takes its
// next value from itself, the operand or a neighbouring cell.
// ----------------------------------------------------------------------------
module sle_cell (
    input  logic                                clk,
    input  sle_pkg::cell_ctrl_t                 ctrl,
    input  logic                                occupied,
    input  logic                                left_less,
    input  logic signed [sle_pkg::VALUE_W-1:0]  left_value,
    input  logic signed [sle_pkg::VALUE_W-1:0]  right_value,
    output logic signed [sle_pkg::VALUE_W-1:0]  value,
    output logic signed [sle_pkg::VALUE_W-1:0]  value_next,
    output logic                                less,
    output logic                                match
);
    import sle_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;

    assign value = value_reg;
    assign less  = occupied && (value_reg < ctrl.operand);
    assign match = occupied && (value_reg == ctrl.operand);

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.cmd)
            CMD_INSERT:
            begin
                // keep smaller entries, open the gap at the boundary, shift the rest up
                if (!less)
                begin
                    value_next = left_less ? ctrl.operand : left_value;
                end
            end
            CMD_SHIFT:
            begin
                value_next = right_value;
            end
            CMD_COMPACT:
            begin
                // drop one matching entry: everything from the first match moves down
                if (!less)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: hdl/sorted_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine_unit: sorted list priority queue on a chain of cells
// Keeps up to DEPTH signed values in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready with the operand in s_tdata and
//   the opcode in s_tuser (insert, remove all equal, pop smallest, clear).
//   Every input beat yields exactly one result beat on m_tvalid/m_tready:
//   smallest entry and count in m_tdata, empty flag and status in m_tuser,
//   all taken after the operation.
//   Insert, pop and clear: the result is registered on the
//   edge that accepts the beat, and the next beat is taken in the same
//   cycle as the result leaves, so these run at one beat per cycle while m_tready stays high.
//   Remove works on k matching entries: the cell chain drops one
//   matching entry per cycle and the pass ends once no entry matches and the
//   result register is free; no input beat is taken meanwhile.
//   A stalled receiver holds the result register; s_tready stays low until
//   it is taken. Reset empties the list (count to zero) and drops any
//   pending result; cell contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] smallest_value, [36:32] entry_count, rest zero
    output logic [2:0]  m_tuser    // [0] is_empty, [2:1] status
);
    import sle_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_REMOVE
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic signed [VALUE_W-1:0] rem_value_reg;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_smallest_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic                      out_empty_reg;
    logic [STATUS_W-1:0]       out_status_reg;

    cell_ctrl_t                ctrl;
    logic [STATUS_W-1:0]       status_next;
    logic                      load_result;
    logic                      out_free;
    logic                      accept;
    logic                      any_match;
    logic [CNT_W+COUNT_W-1:0]  cnt_wide;

    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    logic signed [VALUE_W-1:0] cell_next  [DEPTH];
    logic [DEPTH-1:0]          cell_less;
    logic [DEPTH-1:0]          cell_match;
    logic [DEPTH-1:0]          cell_occ;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign any_match = |cell_match;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign cell_occ[i] = CNT_W'(i) < cnt_reg;
            if (i == 0)
            begin : g_first
                sle_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .occupied    (cell_occ[i]),
                    .left_less   (1'b1),
                    .left_value  (ctrl.operand),
                    .right_value ((DEPTH > 1) ? cell_value[(DEPTH > 1) ? 1 : 0] : cell_value[0]),
                    .value       (cell_value[i]),
                    .value_next  (cell_next[i]),
                    .less        (cell_less[i]),
                    .match       (cell_match[i])
                );
            end
            else if (i == DEPTH - 1)
            begin : g_last
                sle_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .occupied    (cell_occ[i]),
                    .left_less   (cell_less[i-1]),
                    .left_value  (cell_value[i-1]),
                    .right_value (cell_value[i]),
                    .value       (cell_value[i]),
                    .value_next  (cell_next[i]),
                    .less        (cell_less[i]),
                    .match       (cell_match[i])
                );
            end
            else
            begin : g_mid
                sle_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .occupied    (cell_occ[i]),
                    .left_less   (cell_less[i-1]),
                    .left_value  (cell_value[i-1]),
                    .right_value (cell_value[i+1]),
                    .value       (cell_value[i]),
                    .value_next  (cell_next[i]),
                    .less        (cell_less[i]),
                    .match       (cell_match[i])
                );
            end
        end
    endgenerate

    always_comb
    begin
        ctrl.cmd     = CMD_HOLD;
        ctrl.operand = (state_reg == S_REMOVE) ? rem_value_reg : $signed(s_tdata);
        cnt_next     = cnt_reg;
        status_next  = ST_OK;
        state_next   = state_reg;
        load_result  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_tuser)
                        OP_INSERT:
                        begin
                            load_result = 1'b1;
                            if (cnt_reg == CNT_FULL)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.cmd = CMD_INSERT;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            state_next = S_REMOVE;
                        end
                        OP_POP:
                        begin
                            load_result = 1'b1;
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                ctrl.cmd = CMD_SHIFT;
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            load_result = 1'b1;
                            cnt_next    = '0;
                        end
                        default:
                        begin
                            load_result = 1'b0;
                        end
                    endcase
                end
            end
            S_REMOVE:
            begin
                if (any_match)
                begin
                    ctrl.cmd = CMD_COMPACT;
                    cnt_next = cnt_reg - 1'b1;
                end
                else if (out_free)
                begin
                    load_result = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cnt_wide = {{COUNT_W{1'b0}}, cnt_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_smallest_reg <= '0;
            out_count_reg    <= '0;
            out_empty_reg    <= 1'b1;
            out_status_reg   <= ST_OK;
            rem_value_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_result)
            begin
                out_valid_reg    <= 1'b1;
                out_smallest_reg <= (cnt_next == '0) ? '0 : cell_next[0];
                out_count_reg    <= cnt_wide[COUNT_W-1:0];
                out_empty_reg    <= (cnt_next == '0);
                out_status_reg   <= status_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                rem_value_reg <= $signed(s_tdata);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_smallest_reg};
    assign m_tuser  = {out_status_reg, out_empty_reg};

endmodule
